@@ design/kcd_pkg.sv @@
// ----------------------------------------------------------------------------
// kcd_pkg
// Shared types and constants for the k-core decomposition unit.
// ----------------------------------------------------------------------------
package kcd_pkg;

    localparam int NODE_W      = 10;
    localparam int CORE_W      = 13;
    localparam int LEVEL_W     = CORE_W + 1;
    localparam int STATUS_W    = 2;
    localparam int FUNC_W      = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 8192;
    localparam logic [CORE_W-1:0] CORE_SAT = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_COMPUTE = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_BAD_NODE  = 2'd2,
        STATUS_RSVD      = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LD_WR, ST_Q_WT, ST_OUT,
        ST_C_INIT, ST_C_T_RD, ST_C_T_WT, ST_C_T_INC,
        ST_C_S_RD, ST_C_S_WT, ST_C_S_E_RD, ST_C_S_E_WT, ST_C_S_WR,
        ST_P_LVL, ST_P_SC_RD, ST_P_SC_WT, ST_P_FR, ST_P_V_RD, ST_P_V_WT,
        ST_P_V_WT2, ST_P_E_RD, ST_P_E_WT, ST_P_U_WT, ST_M_RD, ST_M_WT
    } state_t;

endpackage

@@ design/kcd_ram.sv @@
// ----------------------------------------------------------------------------
// kcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/kcore_decomposition_unit.sv @@
// ----------------------------------------------------------------------------
// kcore_decomposition_unit
// Edge store and level-synchronous k-core peeling engine.
// ----------------------------------------------------------------------------
// Usage: words enter on s_* (tuser = func). A load stores one edge (sorted by
// source) and gives no result unless the store is full (status 1). A compute
// word derives live degrees and peels the graph; it returns max_core and
// max_degree. A query returns one node's core number (status 2 when the
// node lies above highest_node). Results leave on m_* (tuser = status).
// Compute steps: clear all MAX_NODES tally entries, tally each live stored edge
//   by its target, then count each node's owned live edges; then per peel
//   level scan the nodes and walk each frontier node's edges; finally scan
//   all nodes for max_core.
// All work is done by one sequencer around single-port-read RAMs, so one
// word is taken at a time; s_tready is high only when the sequencer idles.
// After reset a clearing pass over all MAX_NODES entries zeroes the adjacency
// ends and core values; s_tready stays low during it. highest_node resets to 1023.
// When the receiver stalls, the finished result holds in the output register;
// words are still taken until the next result is ready, which then waits
// with s_tready low until the register frees.
// ----------------------------------------------------------------------------
module kcore_decomposition_unit
    import kcd_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [NODE_W-1:0]     cfg_wdata,     // highest_node
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [9:0] source_node, [19:10] target_node, [20] edge_removed,
    // [30:21] query_node, [31] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [FUNC_W-1:0]     s_tuser,       // [1:0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [12:0] core_number, [25:13] max_core, [38:26] max_degree, [39] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [STATUS_W-1:0]   m_tuser        // [1:0] status
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int TW  = ECW + 1;
    localparam int EDW = NODE_W + 1;

    // RAM ports
    logic           ed_we;
    logic [EW-1:0]  ed_waddr, ed_raddr;
    logic [EDW-1:0] ed_wdata, ed_rdata;
    logic           as_we;
    logic [NW-1:0]  as_waddr, as_raddr;
    logic [EW-1:0]  as_wdata, as_rdata;
    logic           ae_we;
    logic [NW-1:0]  ae_waddr, ae_raddr;
    logic [ECW-1:0] ae_wdata, ae_rdata;
    logic           co_we;
    logic [NW-1:0]  co_waddr, co_raddr;
    logic [CORE_W-1:0] co_wdata, co_rdata;
    logic           ta_we;
    logic [NW-1:0]  ta_waddr, ta_raddr;
    logic [TW-1:0]  ta_wdata, ta_rdata;
    logic           f0_we, f1_we;
    logic [NW-1:0]  f0_waddr, f1_waddr, f0_raddr, f1_raddr;
    logic [NW-1:0]  fr_wdata, f0_rdata, f1_rdata;

    kcd_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge (
        .aclk(aclk), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
        .raddr(ed_raddr), .rdata(ed_rdata));
    kcd_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_adj_start (
        .aclk(aclk), .we(as_we), .waddr(as_waddr), .wdata(as_wdata),
        .raddr(as_raddr), .rdata(as_rdata));
    kcd_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES)) u_adj_end (
        .aclk(aclk), .we(ae_we), .waddr(ae_waddr), .wdata(ae_wdata),
        .raddr(ae_raddr), .rdata(ae_rdata));
    kcd_ram #(.WIDTH(CORE_W), .DEPTH(MAX_NODES)) u_core (
        .aclk(aclk), .we(co_we), .waddr(co_waddr), .wdata(co_wdata),
        .raddr(co_raddr), .rdata(co_rdata));
    kcd_ram #(.WIDTH(TW), .DEPTH(MAX_NODES)) u_tally (
        .aclk(aclk), .we(ta_we), .waddr(ta_waddr), .wdata(ta_wdata),
        .raddr(ta_raddr), .rdata(ta_rdata));
    kcd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_front0 (
        .aclk(aclk), .we(f0_we), .waddr(f0_waddr), .wdata(fr_wdata),
        .raddr(f0_raddr), .rdata(f0_rdata));
    kcd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_front1 (
        .aclk(aclk), .we(f1_we), .waddr(f1_waddr), .wdata(fr_wdata),
        .raddr(f1_raddr), .rdata(f1_rdata));

    state_t state_reg, state_next;
    logic [NODE_W-1:0]  hn_reg;
    logic [ECW-1:0]     ecount_reg, ecount_next;
    logic [NCW-1:0]     idx_reg, idx_next;
    logic [ECW-1:0]     j_reg, j_next;
    logic [NCW-1:0]     n_reg, n_next;
    logic [NCW-1:0]     todo_reg, todo_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [NCW-1:0]     cur_reg, cur_next;
    logic [NCW-1:0]     nxt_reg, nxt_next;
    logic               bank_reg, bank_next;
    logic [ECW-1:0]     cnt_reg, cnt_next;
    logic [ECW-1:0]     end_reg, end_next;
    logic [TW-1:0]      tally_reg, tally_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [CORE_W-1:0]  maxd_reg, maxd_next;
    logic [CORE_W-1:0]  maxc_reg, maxc_next;
    logic [NODE_W-1:0]  src_reg, src_next, tgt_reg, tgt_next;
    logic               rem_reg, rem_next;
    logic [CORE_W-1:0]  rcore_reg, rcore_next;
    status_t            rstat_reg, rstat_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]  m_tuser_reg, m_tuser_next;

    logic [NW-1:0] fr_rdata;
    logic [TW-1:0] sum;
    logic [TW-2:0] half;
    logic [NODE_W:0] hn_plus;
    logic [CORE_W-1:0] dec;

    assign fr_rdata = bank_reg ? f1_rdata : f0_rdata;
    assign sum      = tally_reg + TW'(cnt_reg);
    assign half     = sum[TW-1:1];
    assign hn_plus  = {1'b0, hn_reg} + (NODE_W+1)'(1);
    assign dec      = co_rdata - CORE_W'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            hn_reg       <= '1;
            ecount_reg   <= '0;
            idx_reg      <= '0;
            j_reg        <= '0;
            n_reg        <= '0;
            todo_reg     <= '0;
            level_reg    <= '0;
            cur_reg      <= '0;
            nxt_reg      <= '0;
            bank_reg     <= 1'b0;
            cnt_reg      <= '0;
            maxd_reg     <= '0;
            maxc_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_we) begin
                hn_reg <= cfg_wdata;
            end
            ecount_reg   <= ecount_next;
            idx_reg      <= idx_next;
            j_reg        <= j_next;
            n_reg        <= n_next;
            todo_reg     <= todo_next;
            level_reg    <= level_next;
            cur_reg      <= cur_next;
            nxt_reg      <= nxt_next;
            bank_reg     <= bank_next;
            cnt_reg      <= cnt_next;
            maxd_reg     <= maxd_next;
            maxc_reg     <= maxc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_reg     <= end_next;
        tally_reg   <= tally_next;
        node_reg    <= node_next;
        src_reg     <= src_next;
        tgt_reg     <= tgt_next;
        rem_reg     <= rem_next;
        rcore_reg   <= rcore_next;
        rstat_reg   <= rstat_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_comb begin
        state_next = state_reg;
        ecount_next = ecount_reg;
        idx_next = idx_reg;
        j_next = j_reg;
        n_next = n_reg;
        todo_next = todo_reg;
        level_next = level_reg;
        cur_next = cur_reg;
        nxt_next = nxt_reg;
        bank_next = bank_reg;
        cnt_next = cnt_reg;
        end_next = end_reg;
        tally_next = tally_reg;
        node_next = node_reg;
        maxd_next = maxd_reg;
        maxc_next = maxc_reg;
        src_next = src_reg;
        tgt_next = tgt_reg;
        rem_next = rem_reg;
        rcore_next = rcore_reg;
        rstat_next = rstat_reg;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        ed_we = 1'b0; ed_waddr = ecount_reg[EW-1:0];
        ed_wdata = {!rem_reg, tgt_reg}; ed_raddr = j_reg[EW-1:0];
        as_we = 1'b0; as_waddr = NW'(src_reg); as_wdata = ecount_reg[EW-1:0];
        as_raddr = NW'(node_reg);
        ae_we = 1'b0; ae_waddr = NW'(src_reg);
        ae_wdata = ecount_reg + ECW'(1); ae_raddr = NW'(node_reg);
        co_we = 1'b0; co_waddr = NW'(node_reg); co_wdata = dec;
        co_raddr = idx_reg[NW-1:0];
        ta_we = 1'b0; ta_waddr = idx_reg[NW-1:0]; ta_wdata = '0;
        ta_raddr = idx_reg[NW-1:0];
        f0_we = 1'b0; f1_we = 1'b0;
        f0_waddr = cur_reg[NW-1:0]; f1_waddr = cur_reg[NW-1:0];
        fr_wdata = idx_reg[NW-1:0];
        f0_raddr = idx_reg[NW-1:0]; f1_raddr = idx_reg[NW-1:0];

        unique case (state_reg)
            ST_CLEAR: begin
                ae_we = 1'b1; ae_waddr = idx_reg[NW-1:0]; ae_wdata = '0;
                co_we = 1'b1; co_waddr = idx_reg[NW-1:0]; co_wdata = '0;
                idx_next = idx_reg + NCW'(1);
                if (idx_reg == NCW'(MAX_NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                src_next = s_tdata[9:0];
                tgt_next = s_tdata[19:10];
                rem_next = s_tdata[20];
                ae_raddr = NW'(s_tdata[9:0]);
                co_raddr = NW'(s_tdata[30:21]);
                rcore_next = '0;
                maxc_next  = '0;
                maxd_next  = '0;
                if (s_tvalid) begin
                    unique case (func_t'(s_tuser))
                        FUNC_LOAD: begin
                            if (ecount_reg == ECW'(MAX_EDGES)) begin
                                rstat_next = STATUS_FULL;
                                state_next = ST_OUT;
                            end else begin
                                state_next = ST_LD_WR;
                            end
                        end
                        FUNC_COMPUTE: begin
                            rstat_next = STATUS_OK;
                            n_next = (hn_plus > MAX_NODES) ? NCW'(MAX_NODES)
                                                           : NCW'(hn_plus);
                            idx_next = '0;
                            state_next = ST_C_INIT;
                        end
                        FUNC_QUERY: begin
                            if (s_tdata[30:21] > hn_reg ||
                                s_tdata[30:21] >= MAX_NODES) begin
                                rstat_next = STATUS_BAD_NODE;
                                state_next = ST_OUT;
                            end else begin
                                rstat_next = STATUS_OK;
                                state_next = ST_Q_WT;
                            end
                        end
                        FUNC_NOP: begin
                            state_next = ST_IDLE;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LD_WR: begin
                ed_we = 1'b1;
                if (src_reg < MAX_NODES) begin
                    // restart the range when this source did not own the last edge
                    if (ae_rdata != ecount_reg || ecount_reg == '0) begin
                        as_we = 1'b1;
                    end
                    ae_we = 1'b1;
                end
                ecount_next = ecount_reg + ECW'(1);
                state_next = ST_IDLE;
            end
            ST_Q_WT: begin
                rcore_next = co_rdata;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, maxd_reg, maxc_reg, rcore_reg};
                    m_tuser_next  = rstat_reg;
                    state_next    = ST_IDLE;
                end
            end
            // ---------------- degree pass ----------------
            ST_C_INIT: begin
                ta_we = 1'b1;
                idx_next = idx_reg + NCW'(1);
                if (idx_reg == NCW'(MAX_NODES - 1)) begin
                    j_next = '0;
                    state_next = ST_C_T_RD;
                end
            end
            ST_C_T_RD: begin
                if (j_reg == ecount_reg) begin
                    idx_next = '0;
                    state_next = ST_C_S_RD;
                end else begin
                    state_next = ST_C_T_WT;
                end
            end
            ST_C_T_WT: begin
                node_next = ed_rdata[NODE_W-1:0];
                ta_raddr = NW'(ed_rdata[NODE_W-1:0]);
                if (ed_rdata[NODE_W] && ed_rdata[NODE_W-1:0] < n_reg) begin
                    state_next = ST_C_T_INC;
                end else begin
                    j_next = j_reg + ECW'(1);
                    state_next = ST_C_T_RD;
                end
            end
            ST_C_T_INC: begin
                ta_we = 1'b1;
                ta_waddr = NW'(node_reg);
                ta_wdata = ta_rdata + TW'(1);
                j_next = j_reg + ECW'(1);
                state_next = ST_C_T_RD;
            end
            ST_C_S_RD: begin
                as_raddr = idx_reg[NW-1:0];
                ae_raddr = idx_reg[NW-1:0];
                cnt_next = '0;
                if (idx_reg == NCW'(MAX_NODES)) begin
                    todo_next = n_reg;
                    level_next = '0;
                    state_next = ST_P_LVL;
                end else begin
                    state_next = ST_C_S_WT;
                end
            end
            ST_C_S_WT: begin
                end_next = ae_rdata;
                tally_next = ta_rdata;
                j_next = ECW'(as_rdata);
                if (idx_reg < n_reg && ae_rdata != '0) begin
                    state_next = ST_C_S_E_RD;
                end else begin
                    state_next = ST_C_S_WR;
                end
            end
            ST_C_S_E_RD: begin
                if (j_reg == end_reg) begin
                    state_next = ST_C_S_WR;
                end else begin
                    state_next = ST_C_S_E_WT;
                end
            end
            ST_C_S_E_WT: begin
                if (ed_rdata[NODE_W]) begin
                    cnt_next = cnt_reg + ECW'(1);
                end
                j_next = j_reg + ECW'(1);
                state_next = ST_C_S_E_RD;
            end
            ST_C_S_WR: begin
                co_we = 1'b1;
                co_waddr = idx_reg[NW-1:0];
                if (idx_reg >= n_reg) begin
                    co_wdata = '0;
                end else if (half > (TW-1)'(CORE_SAT)) begin
                    co_wdata = CORE_SAT;
                end else begin
                    co_wdata = CORE_W'(half);
                end
                if (co_wdata > maxd_reg) begin
                    maxd_next = co_wdata;
                end
                idx_next = idx_reg + NCW'(1);
                state_next = ST_C_S_RD;
            end
            // ---------------- peeling ----------------
            ST_P_LVL: begin
                idx_next = '0;
                cur_next = '0;
                if (todo_reg == '0 || level_reg > LEVEL_W'(CORE_SAT)) begin
                    state_next = ST_M_RD;
                end else begin
                    state_next = ST_P_SC_RD;
                end
            end
            ST_P_SC_RD: begin
                if (idx_reg == n_reg) begin
                    state_next = ST_P_FR;
                end else begin
                    state_next = ST_P_SC_WT;
                end
            end
            ST_P_SC_WT: begin
                if (LEVEL_W'(co_rdata) == level_reg) begin
                    f0_we = !bank_reg;
                    f1_we = bank_reg;
                    cur_next = cur_reg + NCW'(1);
                end
                idx_next = idx_reg + NCW'(1);
                state_next = ST_P_SC_RD;
            end
            ST_P_FR: begin
                idx_next = '0;
                nxt_next = '0;
                if (cur_reg == '0) begin
                    level_next = level_reg + LEVEL_W'(1);
                    state_next = ST_P_LVL;
                end else begin
                    todo_next = (cur_reg > todo_reg) ? '0 : todo_reg - cur_reg;
                    state_next = ST_P_V_RD;
                end
            end
            ST_P_V_RD: begin
                if (idx_reg == cur_reg) begin
                    // next frontier becomes current: swap banks
                    bank_next = !bank_reg;
                    cur_next = nxt_reg;
                    state_next = ST_P_FR;
                end else begin
                    state_next = ST_P_V_WT;
                end
            end
            ST_P_V_WT: begin
                as_raddr = fr_rdata;
                ae_raddr = fr_rdata;
                state_next = ST_P_V_WT2;
            end
            ST_P_V_WT2: begin
                end_next = ae_rdata;
                j_next = ECW'(as_rdata);
                if (ae_rdata != '0) begin
                    state_next = ST_P_E_RD;
                end else begin
                    idx_next = idx_reg + NCW'(1);
                    state_next = ST_P_V_RD;
                end
            end
            ST_P_E_RD: begin
                if (j_reg == end_reg) begin
                    idx_next = idx_reg + NCW'(1);
                    state_next = ST_P_V_RD;
                end else begin
                    state_next = ST_P_E_WT;
                end
            end
            ST_P_E_WT: begin
                node_next = ed_rdata[NODE_W-1:0];
                co_raddr = NW'(ed_rdata[NODE_W-1:0]);
                if (ed_rdata[NODE_W] && ed_rdata[NODE_W-1:0] < n_reg) begin
                    state_next = ST_P_U_WT;
                end else begin
                    j_next = j_reg + ECW'(1);
                    state_next = ST_P_E_RD;
                end
            end
            ST_P_U_WT: begin
                if (LEVEL_W'(co_rdata) > level_reg) begin
                    co_we = 1'b1;
                    if (LEVEL_W'(dec) == level_reg && nxt_reg < NCW'(MAX_NODES)) begin
                        fr_wdata = NW'(node_reg);
                        f0_waddr = nxt_reg[NW-1:0];
                        f1_waddr = nxt_reg[NW-1:0];
                        f0_we = bank_reg;
                        f1_we = !bank_reg;
                        nxt_next = nxt_reg + NCW'(1);
                    end
                end
                j_next = j_reg + ECW'(1);
                state_next = ST_P_E_RD;
            end
            ST_M_RD: begin
                if (idx_reg == n_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_M_WT;
                end
            end
            ST_M_WT: begin
                if (co_rdata > maxc_reg) begin
                    maxc_next = co_rdata;
                end
                idx_next = idx_reg + NCW'(1);
                state_next = ST_M_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
